@@ design/tsl_pkg.sv @@
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared types, codes and constants of the timestamped record store.
// ----------------------------------------------------------------------------
package tsl_pkg;

    localparam int NVAL = 5;
    localparam int SPW  = 4;

    localparam logic [SPW-1:0] SPAN_RESET = 4'd6;

    localparam logic [1:0] MODE_APPEND  = 2'd0;
    localparam logic [1:0] MODE_NEAREST = 2'd1;
    localparam logic [1:0] MODE_INTERP  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [62:0] W_ONE = 63'h0000_0001_0000_0000;
    localparam logic [62:0] W_CAP = 63'h4000_0000_0000_0000;

    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = 64 / DIV_STEP;
    localparam int DIV_CW     = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        time_stamp;
        logic signed [31:0] value_0;
        logic signed [31:0] value_1;
        logic signed [31:0] value_2;
        logic signed [31:0] value_3;
        logic signed [31:0] value_4;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value_0;
        logic signed [31:0] out_value_1;
        logic signed [31:0] out_value_2;
        logic signed [31:0] out_value_3;
        logic signed [31:0] out_value_4;
    } t_result;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_DECIDE,
        CMD_SRCH_RD,
        CMD_SRCH_UPD,
        CMD_RD_LO,
        CMD_RD_HI,
        CMD_NR_SEL,
        CMD_NR_LOAD,
        CMD_WIN,
        CMD_CLAMP_LO,
        CMD_CLAMP_HI,
        CMD_A_RD,
        CMD_A_CAP,
        CMD_B_RD,
        CMD_DIV_GO,
        CMD_WMUL_GO,
        CMD_W_UPD,
        CMD_B_NEXT,
        CMD_TMUL_GO,
        CMD_T_ACC,
        CMD_A_NEXT,
        CMD_DONE
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECIDE,
        S_SRCH,
        S_SRCH_CMP,
        S_NR_LO,
        S_NR_HI,
        S_NR_SEL,
        S_NR_LOAD,
        S_WIN,
        S_CLAMP_LO,
        S_CLAMP_HI,
        S_A_RD,
        S_A_CAP,
        S_B_RD,
        S_B_DIV,
        S_B_DWAIT,
        S_B_MWAIT,
        S_B_NXT,
        S_T_MUL,
        S_T_WAIT,
        S_A_NXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] mode;
        logic       empty;
        logic       srch_more;
        logic       b_eq_a;
        logic       b_last;
        logic       a_last;
        logic       k_last;
        logic       den_zero;
        logic       div_done;
        logic       mul_done;
    } t_dp_stat;

endpackage

@@ design/tsl_div.sv @@
// ----------------------------------------------------------------------------
// tsl_div
// Radix-16 restoring divider: floor(num * 2^32 / den), 64-bit quotient.
// ----------------------------------------------------------------------------
module tsl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic [63:0] o_quot,
    output logic        o_done
);

    logic                      r_run;
    logic                      r_done;
    logic [tsl_pkg::DIV_CW-1:0] r_cnt;
    logic [63:0]               r_n;
    logic [31:0]               r_rem;
    logic [31:0]               r_den;
    logic [63:0]               n_n;
    logic [31:0]               n_rem;

    always_comb begin
        logic [32:0] rem33;
        logic [63:0] nv;
        nv    = r_n;
        rem33 = {1'b0, r_rem};
        for (int s = 0; s < tsl_pkg::DIV_STEP; s++) begin
            rem33 = {rem33[31:0], nv[63]};
            nv    = {nv[62:0], 1'b0};
            if (rem33 >= {1'b0, r_den}) begin
                rem33 = rem33 - {1'b0, r_den};
                nv[0] = 1'b1;
            end
        end
        n_n   = nv;
        n_rem = rem33[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n   <= {i_num, 32'd0};
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_n   <= n_n;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tsl_pkg::DIV_CW'(tsl_pkg::DIV_CYCLES - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_n;
    assign o_done = r_done;

endmodule

@@ design/tsl_mul.sv @@
// ----------------------------------------------------------------------------
// tsl_mul
// Saturating Q32.32 multiply: min(floor(a*b / 2^32), 2^62), one 32x32 partial
// product per cycle.
// ----------------------------------------------------------------------------
module tsl_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_a,
    input  logic [63:0] i_b,
    output logic [62:0] o_p,
    output logic        o_done
);

    logic        r_run;
    logic        r_done;
    logic        r_pvld;
    logic [2:0]  r_step;
    logic [1:0]  r_pidx;
    logic [62:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_pp;
    logic [95:0] r_acc;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [95:0] addend;

    always_comb begin
        unique case (r_step[1:0])
            2'd0: begin op_a = r_a[31:0];         op_b = r_b[31:0];  end
            2'd1: begin op_a = {1'b0, r_a[62:32]}; op_b = r_b[31:0];  end
            2'd2: begin op_a = r_a[31:0];         op_b = r_b[63:32]; end
            default: begin op_a = {1'b0, r_a[62:32]}; op_b = r_b[63:32]; end
        endcase
    end

    always_comb begin
        unique case (r_pidx)
            2'd0:    addend = 96'(r_pp[63:32]);
            2'd1:    addend = 96'(r_pp);
            2'd2:    addend = 96'(r_pp);
            default: addend = {r_pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_pvld <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_step <= '0;
                r_pvld <= 1'b0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                if (r_step != 3'd4) begin
                    r_pp   <= op_a * op_b;
                    r_pidx <= r_step[1:0];
                    r_pvld <= 1'b1;
                    r_step <= r_step + 3'd1;
                end else begin
                    r_pvld <= 1'b0;
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                if (r_pvld) begin
                    r_acc <= r_acc + addend;
                end
            end
        end
    end

    assign o_p    = (r_acc > 96'(tsl_pkg::W_CAP)) ? tsl_pkg::W_CAP : r_acc[62:0];
    assign o_done = r_done;

endmodule

@@ design/tsl_dp.sv @@
// ----------------------------------------------------------------------------
// tsl_dp
// Datapath: time and record memories, search pointers, window, weights and
// accumulators, with the divider and the shared weight and term multiplier.
// ----------------------------------------------------------------------------
module tsl_dp #(
    parameter int DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsl_pkg::t_cmd      i_cmd,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    input  tsl_pkg::t_item     i_item,
    output tsl_pkg::t_dp_stat  o_stat,
    output logic               o_valid,
    output tsl_pkg::t_result   o_result
);

    localparam int NV = tsl_pkg::NVAL;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (AW + 2 > tsl_pkg::SPW + 1) ? AW + 2 : tsl_pkg::SPW + 1;
    localparam logic signed [64:0] ACC_HI = 65'sh0_4000_0000_0000_0000;
    localparam logic signed [64:0] ACC_LO = -ACC_HI;

    logic [31:0]            time_mem [DEPTH];
    logic [NV-1:0][31:0]    rec_mem  [DEPTH];

    logic [tsl_pkg::SPW-1:0] r_span;
    logic [CW-1:0]          r_fill;
    logic [31:0]            r_last_time;
    logic [1:0]             r_mode;
    logic [31:0]            r_tq;
    logic [NV-1:0][31:0]    r_vals;
    logic [1:0]             r_status;
    logic [AW-1:0]          r_lo;
    logic [AW-1:0]          r_hi;
    logic [AW-1:0]          r_left;
    logic [AW-1:0]          r_right;
    logic [AW-1:0]          r_a;
    logic [AW-1:0]          r_b;
    logic [2:0]             r_k;
    logic [31:0]            r_ta;
    logic [31:0]            r_hold;
    logic [31:0]            r_trd;
    logic [NV-1:0][31:0]    r_rrd;
    logic [62:0]            r_wmag;
    logic                   r_wneg;
    logic signed [63:0]     r_acc [NV];
    logic                   r_valid;
    tsl_pkg::t_result       r_result;

    logic                   full;
    logic                   order_bad;
    logic [AW-1:0]          mid;
    logic [AW-1:0]          win_left;
    logic [AW-1:0]          win_right;
    logic                   nneg;
    logic                   dneg;
    logic [31:0]            num;
    logic [31:0]            den;
    logic [31:0]            di;
    logic [31:0]            dj;
    logic [AW-1:0]          sel;
    logic signed [31:0]     vsel;
    logic                   vneg;
    logic [31:0]            vmag;
    logic [64:0]            acc_sum;
    logic signed [63:0]     acc_next;
    logic                   t_re;
    logic [AW-1:0]          t_addr;
    logic                   r_re;
    logic [AW-1:0]          r_addr;
    logic                   div_start;
    logic [63:0]            div_q;
    logic                   div_done;
    logic                   mul_start;
    logic [63:0]            mul_b;
    logic [62:0]            mul_p;
    logic                   mul_done;
    logic [NV-1:0][31:0]    out_sat;

    assign full      = (r_fill == CW'(DEPTH));
    assign order_bad = (r_fill != '0) && (r_tq <= r_last_time);
    assign mid       = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        logic [XW-1:0] two_j;
        logic [XW-1:0] span_x;
        logic [XW-1:0] left_x;
        logic [XW-1:0] right_x;
        logic [XW-1:0] last_x;
        two_j   = XW'({r_hi, 1'b0});
        span_x  = XW'(r_span);
        left_x  = (two_j >= span_x) ? ((two_j - span_x) >> 1) : '0;
        right_x = left_x + span_x;
        last_x  = XW'(r_fill) - XW'(1);
        if (right_x > last_x) begin
            right_x = last_x;
        end
        win_left  = AW'(left_x);
        win_right = AW'(right_x);
    end

    assign nneg = r_tq < r_trd;
    assign num  = nneg ? (r_trd - r_tq) : (r_tq - r_trd);
    assign dneg = r_ta < r_trd;
    assign den  = dneg ? (r_trd - r_ta) : (r_ta - r_trd);

    assign di  = (r_tq < r_hold) ? (r_hold - r_tq) : (r_tq - r_hold);
    assign dj  = (r_tq < r_trd) ? (r_trd - r_tq) : (r_tq - r_trd);
    assign sel = (di < dj) ? r_lo : r_hi;

    assign vsel = r_rrd[r_k];
    assign vneg = vsel[31];
    assign vmag = vneg ? (~vsel + 32'd1) : vsel;

    always_comb begin
        logic signed [64:0] s;
        logic [64:0]        t;
        t = 65'(mul_p);
        if (r_wneg != vneg) begin
            s = 65'(r_acc[r_k]) - $signed(t);
        end else begin
            s = 65'(r_acc[r_k]) + $signed(t);
        end
        acc_sum = s;
        if (s > ACC_HI) begin
            acc_next = ACC_HI[63:0];
        end else if (s < ACC_LO) begin
            acc_next = ACC_LO[63:0];
        end else begin
            acc_next = s[63:0];
        end
    end

    always_comb begin
        for (int k = 0; k < NV; k++) begin
            if (r_acc[k] > 64'sh0000_0000_7FFF_FFFF) begin
                out_sat[k] = 32'h7FFF_FFFF;
            end else if (r_acc[k] < -64'sh0000_0000_8000_0000) begin
                out_sat[k] = 32'h8000_0000;
            end else begin
                out_sat[k] = r_acc[k][31:0];
            end
        end
    end

    always_comb begin
        t_re   = 1'b0;
        t_addr = r_b;
        r_re   = 1'b0;
        r_addr = r_a;
        unique case (i_cmd)
            tsl_pkg::CMD_SRCH_RD:  begin t_re = 1'b1; t_addr = mid;      end
            tsl_pkg::CMD_RD_LO:    begin t_re = 1'b1; t_addr = r_lo;     end
            tsl_pkg::CMD_RD_HI:    begin t_re = 1'b1; t_addr = r_hi;     end
            tsl_pkg::CMD_NR_SEL:   begin r_re = 1'b1; r_addr = sel;      end
            tsl_pkg::CMD_WIN:      begin t_re = 1'b1; t_addr = win_left; end
            tsl_pkg::CMD_CLAMP_LO: begin t_re = 1'b1; t_addr = r_right;  end
            tsl_pkg::CMD_A_RD: begin
                t_re   = 1'b1;
                t_addr = r_a;
                r_re   = 1'b1;
                r_addr = r_a;
            end
            tsl_pkg::CMD_B_RD:     begin t_re = 1'b1; t_addr = r_b;      end
            default: ;
        endcase
    end

    assign div_start = (i_cmd == tsl_pkg::CMD_DIV_GO) && (den != '0);
    assign mul_start = (i_cmd == tsl_pkg::CMD_WMUL_GO) || (i_cmd == tsl_pkg::CMD_TMUL_GO);
    assign mul_b     = (i_cmd == tsl_pkg::CMD_WMUL_GO) ? div_q : {32'd0, vmag};

    tsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_quot  (div_q),
        .o_done  (div_done)
    );

    tsl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_wmag),
        .i_b     (mul_b),
        .o_p     (mul_p),
        .o_done  (mul_done)
    );

    always_ff @(posedge i_clk) begin
        if (t_re) begin
            r_trd <= time_mem[t_addr];
        end
        if (r_re) begin
            r_rrd <= rec_mem[r_addr];
        end
        if ((i_cmd == tsl_pkg::CMD_DECIDE) && (r_mode == tsl_pkg::MODE_APPEND)
                && !full && !order_bad) begin
            time_mem[r_fill[AW-1:0]] <= r_tq;
            rec_mem[r_fill[AW-1:0]]  <= r_vals;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span  <= tsl_pkg::SPAN_RESET;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_span <= i_cfg_data;
            end
            unique case (i_cmd)
                tsl_pkg::CMD_LOAD: begin
                    r_mode <= i_item.mode;
                    r_tq   <= i_item.time_stamp;
                    r_vals <= {i_item.value_4, i_item.value_3, i_item.value_2,
                               i_item.value_1, i_item.value_0};
                    for (int k = 0; k < NV; k++) begin
                        r_acc[k] <= '0;
                    end
                end
                tsl_pkg::CMD_DECIDE: begin
                    r_status <= tsl_pkg::ST_OK;
                    r_lo     <= '0;
                    r_hi     <= AW'(r_fill - CW'(1));
                    if (r_mode == tsl_pkg::MODE_APPEND) begin
                        if (full) begin
                            r_status <= tsl_pkg::ST_FULL;
                        end else if (order_bad) begin
                            r_status <= tsl_pkg::ST_ORDER;
                        end else begin
                            r_fill      <= r_fill + CW'(1);
                            r_last_time <= r_tq;
                        end
                    end else if ((r_mode == tsl_pkg::MODE_NEAREST
                            || r_mode == tsl_pkg::MODE_INTERP) && (r_fill == '0)) begin
                        r_status <= tsl_pkg::ST_EMPTY;
                    end
                end
                tsl_pkg::CMD_SRCH_UPD: begin
                    if (r_tq > r_trd) begin
                        r_lo <= mid;
                    end else begin
                        r_hi <= mid;
                    end
                end
                tsl_pkg::CMD_RD_HI: r_hold <= r_trd;
                tsl_pkg::CMD_NR_LOAD: begin
                    for (int k = 0; k < NV; k++) begin
                        r_acc[k] <= 64'($signed(r_rrd[k]));
                    end
                end
                tsl_pkg::CMD_WIN: begin
                    r_left  <= win_left;
                    r_right <= win_right;
                end
                tsl_pkg::CMD_CLAMP_LO: begin
                    if (r_tq < r_trd) begin
                        r_tq <= r_trd;
                    end
                end
                tsl_pkg::CMD_CLAMP_HI: begin
                    if (r_tq > r_trd) begin
                        r_tq <= r_trd;
                    end
                    r_a <= r_left;
                end
                tsl_pkg::CMD_A_RD: begin
                    r_b    <= r_left;
                    r_k    <= '0;
                    r_wmag <= tsl_pkg::W_ONE;
                    r_wneg <= 1'b0;
                end
                tsl_pkg::CMD_A_CAP: r_ta <= r_trd;
                tsl_pkg::CMD_DIV_GO: begin
                    if (den == '0) begin
                        r_wmag <= '0;
                    end else begin
                        r_wneg <= r_wneg ^ nneg ^ dneg;
                    end
                end
                tsl_pkg::CMD_W_UPD:  r_wmag <= mul_p;
                tsl_pkg::CMD_B_NEXT: r_b <= r_b + AW'(1);
                tsl_pkg::CMD_T_ACC: begin
                    r_acc[r_k] <= acc_next;
                    r_k        <= r_k + 3'd1;
                end
                tsl_pkg::CMD_A_NEXT: r_a <= r_a + AW'(1);
                tsl_pkg::CMD_DONE: begin
                    r_valid               <= 1'b1;
                    r_result.status       <= r_status;
                    r_result.out_value_0  <= out_sat[0];
                    r_result.out_value_1  <= out_sat[1];
                    r_result.out_value_2  <= out_sat[2];
                    r_result.out_value_3  <= out_sat[3];
                    r_result.out_value_4  <= out_sat[4];
                end
                default: ;
            endcase
        end
    end

    assign o_stat.mode      = r_mode;
    assign o_stat.empty     = (r_fill == '0);
    assign o_stat.srch_more = (r_hi - r_lo) > AW'(1);
    assign o_stat.b_eq_a    = (r_b == r_a);
    assign o_stat.b_last    = (r_b == r_right);
    assign o_stat.a_last    = (r_a == r_right);
    assign o_stat.k_last    = (r_k == 3'(NV - 1));
    assign o_stat.den_zero  = (den == '0);
    assign o_stat.div_done  = div_done;
    assign o_stat.mul_done  = mul_done;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == tsl_pkg::CMD_SRCH_RD) |-> (r_lo < mid) && (mid < r_hi))
        else $error("search probe outside bracket");

    a_acc_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == tsl_pkg::CMD_T_ACC) |-> mul_done)
        else $error("term accumulated without product");

    a_a_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == tsl_pkg::CMD_A_RD) |-> (r_left <= r_a) && (r_a <= r_right))
        else $error("point index outside window");

endmodule

@@ design/tsl_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsl_ctrl
// Controller: sequences append, search, nearest pick and interpolation.
// ----------------------------------------------------------------------------
module tsl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tsl_pkg::t_dp_stat i_stat,
    output tsl_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    tsl_pkg::t_state r_state;
    tsl_pkg::t_state n_state;
    logic            is_query;

    assign is_query = (i_stat.mode == tsl_pkg::MODE_NEAREST)
                   || (i_stat.mode == tsl_pkg::MODE_INTERP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = tsl_pkg::CMD_NOP;
        unique case (r_state)
            tsl_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd   = tsl_pkg::CMD_LOAD;
                    n_state = tsl_pkg::S_DECIDE;
                end
            end
            tsl_pkg::S_DECIDE: begin
                o_cmd   = tsl_pkg::CMD_DECIDE;
                n_state = (is_query && !i_stat.empty) ? tsl_pkg::S_SRCH : tsl_pkg::S_DONE;
            end
            tsl_pkg::S_SRCH: begin
                if (i_stat.srch_more) begin
                    o_cmd   = tsl_pkg::CMD_SRCH_RD;
                    n_state = tsl_pkg::S_SRCH_CMP;
                end else if (i_stat.mode == tsl_pkg::MODE_NEAREST) begin
                    n_state = tsl_pkg::S_NR_LO;
                end else begin
                    n_state = tsl_pkg::S_WIN;
                end
            end
            tsl_pkg::S_SRCH_CMP: begin
                o_cmd   = tsl_pkg::CMD_SRCH_UPD;
                n_state = tsl_pkg::S_SRCH;
            end
            tsl_pkg::S_NR_LO: begin
                o_cmd   = tsl_pkg::CMD_RD_LO;
                n_state = tsl_pkg::S_NR_HI;
            end
            tsl_pkg::S_NR_HI: begin
                o_cmd   = tsl_pkg::CMD_RD_HI;
                n_state = tsl_pkg::S_NR_SEL;
            end
            tsl_pkg::S_NR_SEL: begin
                o_cmd   = tsl_pkg::CMD_NR_SEL;
                n_state = tsl_pkg::S_NR_LOAD;
            end
            tsl_pkg::S_NR_LOAD: begin
                o_cmd   = tsl_pkg::CMD_NR_LOAD;
                n_state = tsl_pkg::S_DONE;
            end
            tsl_pkg::S_WIN: begin
                o_cmd   = tsl_pkg::CMD_WIN;
                n_state = tsl_pkg::S_CLAMP_LO;
            end
            tsl_pkg::S_CLAMP_LO: begin
                o_cmd   = tsl_pkg::CMD_CLAMP_LO;
                n_state = tsl_pkg::S_CLAMP_HI;
            end
            tsl_pkg::S_CLAMP_HI: begin
                o_cmd   = tsl_pkg::CMD_CLAMP_HI;
                n_state = tsl_pkg::S_A_RD;
            end
            tsl_pkg::S_A_RD: begin
                o_cmd   = tsl_pkg::CMD_A_RD;
                n_state = tsl_pkg::S_A_CAP;
            end
            tsl_pkg::S_A_CAP: begin
                o_cmd   = tsl_pkg::CMD_A_CAP;
                n_state = tsl_pkg::S_B_RD;
            end
            tsl_pkg::S_B_RD: begin
                if (i_stat.b_eq_a) begin
                    o_cmd   = tsl_pkg::CMD_B_NEXT;
                    n_state = i_stat.b_last ? tsl_pkg::S_T_MUL : tsl_pkg::S_B_RD;
                end else begin
                    o_cmd   = tsl_pkg::CMD_B_RD;
                    n_state = tsl_pkg::S_B_DIV;
                end
            end
            tsl_pkg::S_B_DIV: begin
                o_cmd   = tsl_pkg::CMD_DIV_GO;
                n_state = i_stat.den_zero ? tsl_pkg::S_B_NXT : tsl_pkg::S_B_DWAIT;
            end
            tsl_pkg::S_B_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd   = tsl_pkg::CMD_WMUL_GO;
                    n_state = tsl_pkg::S_B_MWAIT;
                end
            end
            tsl_pkg::S_B_MWAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd   = tsl_pkg::CMD_W_UPD;
                    n_state = tsl_pkg::S_B_NXT;
                end
            end
            tsl_pkg::S_B_NXT: begin
                o_cmd   = tsl_pkg::CMD_B_NEXT;
                n_state = i_stat.b_last ? tsl_pkg::S_T_MUL : tsl_pkg::S_B_RD;
            end
            tsl_pkg::S_T_MUL: begin
                o_cmd   = tsl_pkg::CMD_TMUL_GO;
                n_state = tsl_pkg::S_T_WAIT;
            end
            tsl_pkg::S_T_WAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd   = tsl_pkg::CMD_T_ACC;
                    n_state = i_stat.k_last ? tsl_pkg::S_A_NXT : tsl_pkg::S_T_MUL;
                end
            end
            tsl_pkg::S_A_NXT: begin
                o_cmd   = tsl_pkg::CMD_A_NEXT;
                n_state = i_stat.a_last ? tsl_pkg::S_DONE : tsl_pkg::S_A_RD;
            end
            tsl_pkg::S_DONE: begin
                o_cmd   = tsl_pkg::CMD_DONE;
                n_state = tsl_pkg::S_IDLE;
            end
            default: begin
                n_state = tsl_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != tsl_pkg::S_IDLE);

endmodule

@@ design/timestamped_record_store_lookup.sv @@
// ----------------------------------------------------------------------------
// timestamped_record_store_lookup
// Record store with append, nearest-entry lookup and Lagrange interpolation.
//
//   channel   signals                       direction  handshake
//   item      start, busy, i_item           in         start & !busy
//   result    o_valid, o_result             out        one-cycle strobe
//   config    i_cfg_we, i_cfg_data          in         write on i_cfg_we
//
// Append, mode 3 and empty-store queries: load, decide, then the done strobe.
// Nearest: binary search in the one-port time memory, then bracket reads.
// Interpolated: search, window, clamps; per window point a divide and a
//   weight multiply per other point, a term multiply per value; these dominate.
// Reset clears the fill count and sets the span to 6; no clearing pass.
// busy is high from acceptance to the strobe; results are never held off.
// ----------------------------------------------------------------------------
module timestamped_record_store_lookup #(
    parameter int DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tsl_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic [3:0]       i_cfg_data,
    output logic             o_valid,
    output tsl_pkg::t_result o_result
);

    tsl_pkg::t_cmd     cmd;
    tsl_pkg::t_dp_stat stat;

    tsl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tsl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the timestamped record store. A short table of directed items
// covers empty-store queries, the unused mode, order errors, ties and the
// extremes of the values; random phases then append, query and fill the store
// to full under several interpolation spans and idle patterns. Every result is
// checked field by field against a fixed result or a built-in store predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import tsl_pkg::*;

    localparam int          DEPTH       = 1024;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam longint      LIMIT       = 5_000_000;
    localparam logic [31:0] VMAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] VMIN        = 32'h8000_0000;
    localparam longint unsigned WCAP    = 64'h4000_0000_0000_0000;

    typedef struct {
        t_item   item;
        bit      fixed;
        t_result res;
    } dir_row_t;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    i_cfg_we;
    logic [3:0] i_cfg_data;
    logic    o_valid;
    t_result o_result;

    logic [31:0] ts_mem [0:DEPTH-1];
    logic [31:0] rec_mem [0:DEPTH-1][0:NVAL-1];
    int          fill;
    logic [3:0]  span;

    t_result     expected_q[$];
    int          errors;
    longint      cycles;
    int          sender_idle;
    dir_row_t    dir_rows[$];

    timestamped_record_store_lookup #(.DEPTH(DEPTH)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned wmul(longint unsigned a, longint unsigned b);
        longint unsigned a0, a1, b0, b1, hh, s, t;
        a0 = a & 64'hFFFF_FFFF; a1 = a >> 32;
        b0 = b & 64'hFFFF_FFFF; b1 = b >> 32;
        hh = a1 * b1;
        if (hh >= (64'd1 << 30)) return WCAP;
        s = hh << 32;
        t = a1 * b0;
        if (t > WCAP - s) return WCAP;
        s += t;
        t = a0 * b1;
        if (t > WCAP - s) return WCAP;
        s += t;
        t = (a0 * b0) >> 32;
        if (t > WCAP - s) return WCAP;
        return s + t;
    endfunction

    function automatic longint unsigned tdiff(logic [31:0] x, logic [31:0] y, output bit neg);
        neg = x < y;
        return (x >= y) ? longint'(x - y) : longint'(y - x);
    endfunction

    function automatic t_result lookup_result(t_item it);
        t_result r;
        longint acc[NVAL];
        logic [31:0] vals[NVAL];
        logic [31:0] t, tq;
        int i, j, m, sel, lo, hi;
        bit dn, nneg, dneg, wneg;
        longint unsigned di, dj, num, den, q, rt, wmag, vm;
        longint v, term, s;
        vals = '{it.value_0, it.value_1, it.value_2, it.value_3, it.value_4};
        t = it.time_stamp;
        r = '0;
        foreach (acc[k]) acc[k] = 0;
        if (it.mode == MODE_APPEND) begin
            if (fill >= DEPTH) begin
                r.status = ST_FULL;
            end else if (fill > 0 && t <= ts_mem[fill-1]) begin
                r.status = ST_ORDER;
            end else begin
                ts_mem[fill] = t;
                foreach (vals[k]) rec_mem[fill][k] = vals[k];
                fill++;
            end
        end else if (it.mode == MODE_NEAREST || it.mode == MODE_INTERP) begin
            if (fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                i = 0;
                j = fill - 1;
                while (j - i > 1) begin
                    m = i + (j - i) / 2;
                    if (t > ts_mem[m]) i = m; else j = m;
                end
                if (it.mode == MODE_NEAREST) begin
                    di = tdiff(t, ts_mem[i], dn);
                    dj = tdiff(t, ts_mem[j], dn);
                    sel = (di < dj) ? i : j;
                    foreach (acc[k]) acc[k] = longint'(signed'(rec_mem[sel][k]));
                end else begin
                    lo = (2 * j >= span) ? (2 * j - span) / 2 : 0;
                    hi = lo + span;
                    if (hi > fill - 1) hi = fill - 1;
                    tq = t;
                    if (tq < ts_mem[lo]) tq = ts_mem[lo];
                    if (tq > ts_mem[hi]) tq = ts_mem[hi];
                    for (int a = lo; a <= hi; a++) begin
                        wmag = 64'd1 << 32;
                        wneg = 1'b0;
                        for (int b = lo; b <= hi; b++) begin
                            if (a == b) continue;
                            num = tdiff(tq, ts_mem[b], nneg);
                            den = tdiff(ts_mem[a], ts_mem[b], dneg);
                            if (den == 0) begin
                                wmag = 0;
                                continue;
                            end
                            q = num / den;
                            rt = (q << 32) + (((num % den) << 32) / den);
                            wmag = wmul(wmag, rt);
                            wneg = wneg ^ nneg ^ dneg;
                        end
                        for (int k = 0; k < NVAL; k++) begin
                            v = longint'(signed'(rec_mem[a][k]));
                            vm = (v < 0) ? longint'(-v) : longint'(v);
                            term = longint'(wmul(wmag, vm));
                            if (wneg != (v < 0)) term = -term;
                            s = acc[k] + term;
                            if (s > longint'(WCAP)) s = longint'(WCAP);
                            if (s < -longint'(WCAP)) s = -longint'(WCAP);
                            acc[k] = s;
                        end
                    end
                end
            end
        end
        foreach (acc[k]) begin
            if (acc[k] > 64'sd2147483647) acc[k] = 64'sd2147483647;
            if (acc[k] < -64'sd2147483648) acc[k] = -64'sd2147483648;
        end
        r.out_value_0 = acc[0][31:0];
        r.out_value_1 = acc[1][31:0];
        r.out_value_2 = acc[2][31:0];
        r.out_value_3 = acc[3][31:0];
        r.out_value_4 = acc[4][31:0];
        return r;
    endfunction

    function automatic t_item mk_item(logic [1:0] m, logic [31:0] t, logic [31:0] a,
                                      logic [31:0] b, logic [31:0] c, logic [31:0] d,
                                      logic [31:0] e);
        t_item it;
        it.mode = m; it.time_stamp = t;
        it.value_0 = a; it.value_1 = b; it.value_2 = c; it.value_3 = d; it.value_4 = e;
        return it;
    endfunction

    function automatic t_result mk_res(logic [1:0] st, logic [31:0] a, logic [31:0] b,
                                       logic [31:0] c, logic [31:0] d, logic [31:0] e);
        t_result r;
        r.status = st;
        r.out_value_0 = a; r.out_value_1 = b; r.out_value_2 = c;
        r.out_value_3 = d; r.out_value_4 = e;
        return r;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return VMIN;
            1: return VMAX;
            2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        errors++;
    endtask

    task automatic send(t_item it, t_result fixed_res, bit fixed);
        t_result r;
        if (sender_idle > 0 && $urandom_range(1, 100) <= sender_idle) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        r = lookup_result(it);
        expected_q.push_back(fixed ? fixed_res : r);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_span(logic [3:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        span = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_append();
        logic [31:0] last, room, t;
        int left;
        last = (fill > 0) ? ts_mem[fill-1] : 32'd0;
        if (fill > 0 && $urandom_range(1, 100) <= 8) begin
            t = last - $urandom_range(0, (last > 1000) ? 1000 : last);
        end else if (fill == 0) begin
            t = $urandom_range(0, 1000);
        end else begin
            room = 32'hFFFF_FFFF - last;
            left = (fill < DEPTH) ? DEPTH - fill : 1;
            if (fill == DEPTH - 1) t = 32'hFFFF_FFFF;
            else if (room / left <= 1) t = last + 1;
            else if ($urandom_range(0, 2) == 0) t = last + $urandom_range(1, 16);
            else t = last + $urandom_range(1, room / left);
        end
        send(mk_item(MODE_APPEND, t, rand_value(), rand_value(), rand_value(),
                     rand_value(), rand_value()), '0, 1'b0);
    endtask

    task automatic send_query(logic [1:0] m);
        logic [31:0] t;
        if (fill == 0 || $urandom_range(0, 3) == 0) t = $urandom;
        else t = ts_mem[$urandom_range(0, fill - 1)] + $urandom_range(0, 64) - 32;
        send(mk_item(m, t, $urandom, $urandom, $urandom, $urandom, $urandom), '0, 1'b0);
    endtask

    task automatic run_phase(logic [3:0] sp, int n, int idle, int interp_pct);
        int roll;
        write_span(sp);
        sender_idle = idle;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(1, 100);
            if (roll <= interp_pct) send_query(MODE_INTERP);
            else if (roll <= interp_pct + 30) send_query(MODE_NEAREST);
            else if (roll <= interp_pct + 34) send_query(MODE_UNUSED);
            else send_append();
        end
    endtask

    always @(posedge i_clk) begin
        t_result w;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("unexpected result, status %0d", o_result.status);
                errors++;
            end else begin
                w = expected_q.pop_front();
                if (o_result.status != w.status)
                    report("status", o_result.status, w.status);
                if (o_result.out_value_0 != w.out_value_0)
                    report("out_value_0", o_result.out_value_0, w.out_value_0);
                if (o_result.out_value_1 != w.out_value_1)
                    report("out_value_1", o_result.out_value_1, w.out_value_1);
                if (o_result.out_value_2 != w.out_value_2)
                    report("out_value_2", o_result.out_value_2, w.out_value_2);
                if (o_result.out_value_3 != w.out_value_3)
                    report("out_value_3", o_result.out_value_3, w.out_value_3);
                if (o_result.out_value_4 != w.out_value_4)
                    report("out_value_4", o_result.out_value_4, w.out_value_4);
            end
        end
    end

    initial begin
        errors      = 0;
        cycles      = 0;
        fill        = 0;
        span        = SPAN_RESET;
        sender_idle = 11;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;

        dir_rows.push_back('{mk_item(MODE_NEAREST, 32'd0, 0, 0, 0, 0, 0), 1,
                             mk_res(ST_EMPTY, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_INTERP, 32'hFFFF_FFFF, VMAX, VMIN, 0, 0, 0), 1,
                             mk_res(ST_EMPTY, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_UNUSED, 32'h1234, VMAX, VMAX, VMAX, VMAX, VMAX), 1,
                             mk_res(ST_OK, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_APPEND, 32'd0, VMIN, VMAX, 0, 32'hFFFF_FFFF, 1), 1,
                             mk_res(ST_OK, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_APPEND, 32'd0, 5, 5, 5, 5, 5), 1,
                             mk_res(ST_ORDER, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_APPEND, 32'h10000, VMAX, VMIN, 32'h10000,
                                     32'hFFFF_0000, 0), 1, mk_res(ST_OK, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_NEAREST, 32'h8000, 0, 0, 0, 0, 0), 1,
                             mk_res(ST_OK, VMAX, VMIN, 32'h10000, 32'hFFFF_0000, 0)});
        dir_rows.push_back('{mk_item(MODE_NEAREST, 32'h7FFF, 0, 0, 0, 0, 0), 1,
                             mk_res(ST_OK, VMIN, VMAX, 0, 32'hFFFF_FFFF, 1)});
        dir_rows.push_back('{mk_item(MODE_NEAREST, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1,
                             mk_res(ST_OK, VMAX, VMIN, 32'h10000, 32'hFFFF_0000, 0)});
        dir_rows.push_back('{mk_item(MODE_APPEND, 32'h20000, 32'h20000, VMIN, VMAX, 7,
                                     32'hFFFF_FFF9), 1, mk_res(ST_OK, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_APPEND, 32'h30000, VMAX, VMAX, VMIN, VMIN,
                                     32'h30000), 1, mk_res(ST_OK, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_INTERP, 32'h18000, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk_item(MODE_INTERP, 32'd0, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk_item(MODE_INTERP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk_item(MODE_APPEND, 32'h10000, 1, 2, 3, 4, 5), 1,
                             mk_res(ST_ORDER, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_APPEND, 32'h0040_0000, VMIN, VMIN, VMIN, VMIN,
                                     VMIN), 1, mk_res(ST_OK, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(MODE_INTERP, 32'h0020_0000, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk_item(MODE_INTERP, 32'h28000, 0, 0, 0, 0, 0), 0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send(dir_rows[r].item, dir_rows[r].res, dir_rows[r].fixed);

        run_phase(4'd1,  130, 11, 30);
        run_phase(4'd0,  100, 11, 30);
        run_phase(4'd15,  90, 11, 6);
        run_phase(4'd2,  130, 53, 30);
        run_phase(4'd6,  130, 53, 25);
        run_phase(4'd3,  130, 0, 30);
        run_phase(4'd4,  100, 0, 30);
        sender_idle = 0;
        while (fill < DEPTH) send_append();
        repeat (3) send_append();
        run_phase(4'd15, 40, 0, 10);
        run_phase(4'd9,  60, 0, 25);

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/tsl_pkg.sv
design/tsl_div.sv
design/tsl_mul.sv
design/tsl_dp.sv
design/tsl_ctrl.sv
design/timestamped_record_store_lookup.sv
tb/tb_top.sv
